### sv/assert_macros.svh
// Assertion macros shared by the response deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising clock edge outside reset.
`define LRFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define LRFR_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

### sv/lrfr_pkg.sv
// Shared types, constants and CRC function of the response deframer.
package lrfr_pkg;

    localparam logic [7:0]  HDR_BYTE   = 8'hFA;
    localparam logic [7:0]  CMD_MEAS   = 8'hE0;
    localparam logic [7:0]  CMD_VER    = 8'h43;
    localparam logic [7:0]  CMD_ERR    = 8'h65;
    localparam logic [7:0]  CMD_MODE   = 8'h61;
    localparam logic [7:0]  CMD_INTV   = 8'h62;
    localparam logic [7:0]  CMD_FILT   = 8'h59;
    localparam logic [7:0]  WRITE_BIT  = 8'h80;
    localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [4:0]  LEN_SHORT  = 5'd12;
    localparam logic [4:0]  LEN_LONG   = 5'd24;
    localparam logic [4:0]  TRAILER    = 5'd4;
    localparam logic [4:0]  DATA_FIRST = 5'd4;
    localparam int          DATA_BYTES = 8;

    // Result kinds
    localparam logic [2:0] KIND_MEAS    = 3'd0;
    localparam logic [2:0] KIND_VER     = 3'd1;
    localparam logic [2:0] KIND_MODE    = 3'd2;
    localparam logic [2:0] KIND_INTV    = 3'd3;
    localparam logic [2:0] KIND_FILT    = 3'd4;
    localparam logic [2:0] KIND_ERR     = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;
    localparam logic [2:0] KIND_BADCRC  = 3'd7;

    // One completed frame handed from the collector to the decoder.
    typedef struct packed {
        logic [7:0]                cmd;
        logic                      crc_ok;
        logic [DATA_BYTES*8-1:0]   data;   // frame bytes 4..11, byte 4 lowest
    } t_frame_rec;

    // MSB-first CRC-32 update over one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### sv/lidar_response_frame_receiver_top.sv
// Top level of the response frame deframer.
// Usage:
//   Input channel: one received byte per word on i_rx_byte with i_rx_valid;
//   a word is taken at a clock edge where i_rx_valid is high and o_rx_stall low.
//   While idle every byte but the header 0xFA is dropped. Byte 1 is the command;
//   the frame is 24 bytes for the measurement command 0xE0 and 12 otherwise, the
//   last four bytes being a little-endian, MSB-first CRC-32 over the rest.
//   Output channel: one result word per completed frame, o_res_valid with
//   i_res_stall; the word holds while stalled.
// Throughput: one byte per cycle while o_rx_stall is low, set by the byte-wide
//   CRC update in the collector. o_res_valid rises once the frame has passed the
//   queue into the output register, when that register is empty or being taken.
// A two-frame queue parts collector and decoder; o_rx_stall rises only when it
//   is full, that is when the receiver stalls across whole frames.
// Reset (synchronous, active low) puts the collector in header hunt, empties the
//   queue and drops any pending result.
module lidar_response_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [2:0]  o_frame_kind,
    output logic [7:0]  o_raw_command,
    output logic [15:0] o_distance,
    output logic [15:0] o_temperature,
    output logic [15:0] o_amplitude,
    output logic [15:0] o_background_light,
    output logic [7:0]  o_version_major,
    output logic [7:0]  o_version_minor,
    output logic [7:0]  o_version_patch,
    output logic [15:0] o_setting_value
);
    import lrfr_pkg::*;

    logic       q_full, q_push, q_pop, q_head_valid;
    t_frame_rec q_in, q_head;

    lrfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_rx_stall (o_rx_stall),
        .o_push     (q_push),
        .o_rec      (q_in)
    );

    lrfr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_rec        (q_in),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    lrfr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head_valid       (q_head_valid),
        .i_head             (q_head),
        .o_pop              (q_pop),
        .i_res_stall        (i_res_stall),
        .o_res_valid        (o_res_valid),
        .o_frame_kind       (o_frame_kind),
        .o_raw_command      (o_raw_command),
        .o_distance         (o_distance),
        .o_temperature      (o_temperature),
        .o_amplitude        (o_amplitude),
        .o_background_light (o_background_light),
        .o_version_major    (o_version_major),
        .o_version_minor    (o_version_minor),
        .o_version_patch    (o_version_patch),
        .o_setting_value    (o_setting_value)
    );

endmodule

### sv/lrfr_front.sv
// Byte collector: header hunt, running CRC, payload capture, frame completion.
`include "assert_macros.svh"
module lrfr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_q_full,
    output logic               o_rx_stall,
    output logic               o_push,
    output lrfr_pkg::t_frame_rec o_rec
);
    import lrfr_pkg::*;

    logic [4:0]              r_cnt,  n_cnt;
    logic [31:0]             r_crc,  n_crc;
    logic [31:0]             r_rcrc, n_rcrc;
    logic [7:0]              r_cmd,  n_cmd;
    logic [DATA_BYTES*8-1:0] r_data, n_data;

    logic       accept;
    logic [7:0] cmd_now;
    logic [4:0] len;
    logic       in_body;
    logic       is_last;
    logic [31:0] rcrc_upd;

    assign o_rx_stall = i_q_full;
    assign accept     = i_rx_valid && !i_q_full;

    // Frame length follows the command byte, which may be arriving now
    always_comb begin
        cmd_now  = (r_cnt == 5'd1) ? i_rx_byte : r_cmd;
        len      = (cmd_now == CMD_MEAS) ? LEN_LONG : LEN_SHORT;
        in_body  = r_cnt < (len - TRAILER);
        is_last  = (r_cnt != 5'd0) && (r_cnt == len - 5'd1);
        // trailer starts at a multiple of four, so the low count bits pick the lane
        rcrc_upd = r_rcrc | ({24'h0, i_rx_byte} << {r_cnt[1:0], 3'b000});
    end

    // Next-state logic
    always_comb begin
        n_cnt  = r_cnt;
        n_crc  = r_crc;
        n_rcrc = r_rcrc;
        n_cmd  = r_cmd;
        n_data = r_data;
        if (accept) begin
            if (r_cnt == 5'd0) begin
                if (i_rx_byte == HDR_BYTE) begin
                    n_cnt  = 5'd1;
                    n_crc  = crc_byte(CRC_INIT, i_rx_byte);
                    n_rcrc = '0;
                end
            end else if (is_last) begin
                n_cnt  = 5'd0;
                n_crc  = CRC_INIT;
                n_rcrc = '0;
            end else begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd1) begin
                    n_cmd = i_rx_byte;
                end
                if (in_body) begin
                    n_crc = crc_byte(r_crc, i_rx_byte);
                end else begin
                    n_rcrc = rcrc_upd;
                end
                for (int k = 0; k < DATA_BYTES; k++) begin
                    if (r_cnt == DATA_FIRST + 5'(k)) begin
                        n_data[k*8 +: 8] = i_rx_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_crc  <= CRC_INIT;
            r_rcrc <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_crc  <= n_crc;
            r_rcrc <= n_rcrc;
        end
        r_cmd  <= n_cmd;
        r_data <= n_data;
    end

    // Completed frame; the last byte is always the top trailer byte
    assign o_push        = accept && is_last;
    assign o_rec.cmd     = r_cmd;
    assign o_rec.crc_ok  = (r_crc == rcrc_upd);
    assign o_rec.data    = r_data;

    `LRFR_NEVER(a_cnt_range, r_cnt >= LEN_LONG, "byte count beyond longest frame")
    `LRFR_ASSERT(a_long_done, accept && r_cnt == LEN_LONG - 5'd1 |-> o_push,
                 "long frame last byte did not complete a frame")
    `LRFR_ASSERT(a_push_idle, o_push |=> r_cnt == 5'd0 && r_crc == CRC_INIT,
                 "collector not back to idle after a frame")

endmodule

### sv/lrfr_queue.sv
// Two-entry frame queue between collector and decoder.
`include "assert_macros.svh"
module lrfr_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lrfr_pkg::t_frame_rec i_rec,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_head_valid,
    output lrfr_pkg::t_frame_rec o_head
);
    import lrfr_pkg::*;

    t_frame_rec r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    `LRFR_NEVER(a_overflow, i_push && o_full && !i_pop, "push into full queue")
    `LRFR_NEVER(a_underflow, i_pop && !o_head_valid, "pop from empty queue")

endmodule

### sv/lrfr_back.sv
// Frame decoder and output register.
`include "assert_macros.svh"
module lrfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  lrfr_pkg::t_frame_rec i_head,
    output logic                 o_pop,
    input  logic                 i_res_stall,
    output logic                 o_res_valid,
    output logic [2:0]           o_frame_kind,
    output logic [7:0]           o_raw_command,
    output logic [15:0]          o_distance,
    output logic [15:0]          o_temperature,
    output logic [15:0]          o_amplitude,
    output logic [15:0]          o_background_light,
    output logic [7:0]           o_version_major,
    output logic [7:0]           o_version_minor,
    output logic [7:0]           o_version_patch,
    output logic [15:0]          o_setting_value
);
    import lrfr_pkg::*;

    logic        r_valid;
    logic [2:0]  kind;
    logic [7:0]  base;
    logic [63:0] d;
    logic [63:0] meas;
    logic [23:0] ver;
    logic [15:0] setv;

    assign o_pop = i_head_valid && (!r_valid || !i_res_stall);
    assign d     = i_head.data;
    assign base  = i_head.cmd & ~WRITE_BIT;

    // Decode by command
    always_comb begin
        kind = KIND_UNKNOWN;
        meas = '0;
        ver  = '0;
        setv = '0;
        if (!i_head.crc_ok) begin
            kind = KIND_BADCRC;
        end else if (i_head.cmd == CMD_MEAS) begin
            kind = KIND_MEAS;
            meas = d;
        end else if (i_head.cmd == CMD_VER) begin
            kind = KIND_VER;
            ver  = {d[23:16], d[15:8], d[7:0]};
        end else if (i_head.cmd == CMD_ERR) begin
            kind = KIND_ERR;
            setv = {8'h00, d[7:0]};
        end else if (base == CMD_MODE) begin
            kind = KIND_MODE;
            setv = {8'h00, d[7:0]};
        end else if (base == CMD_INTV) begin
            kind = KIND_INTV;
            setv = d[15:0];
        end else if (base == CMD_FILT) begin
            kind = KIND_FILT;
            setv = {8'h00, d[7:0]};
        end
    end

    // Output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_frame_kind       <= kind;
            o_raw_command      <= i_head.cmd;
            o_distance         <= meas[15:0];
            o_temperature      <= meas[31:16];
            o_amplitude        <= meas[47:32];
            o_background_light <= meas[63:48];
            o_version_major    <= ver[23:16];
            o_version_minor    <= ver[15:8];
            o_version_patch    <= ver[7:0];
            o_setting_value    <= setv;
        end
    end

    assign o_res_valid = r_valid;

    `LRFR_ASSERT(a_pop_shows, o_pop |=> o_res_valid, "popped frame not presented")
    `LRFR_NEVER(a_pop_blocked, o_pop && r_valid && i_res_stall,
                "held result overwritten")

endmodule
